// ===== src/three_wire_spi_9bit_master_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the 9-bit three-wire SPI
// master.
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_SPI_9BIT_MASTER_DEFINES_SVH
`define THREE_WIRE_SPI_9BIT_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWS9_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWS9_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tws9_pkg.sv =====
// ----------------------------------------------------------------------------
// tws9_pkg
// Types and constants of the 9-bit three-wire SPI master.
// ----------------------------------------------------------------------------
package tws9_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned PHASE_W        = 5;

  // Item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Transaction modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RCMD  = 2'd2;
  localparam logic [1:0] MODE_RDATA = 2'd3;

  // Half-period numbering inside a frame or a read byte.
  localparam logic [PHASE_W-1:0] FRAME_TICKS    = PHASE_W'(18);
  localparam logic [PHASE_W-1:0] WRITE_TAIL     = PHASE_W'(18);
  localparam logic [PHASE_W-1:0] WRITE_DONE     = PHASE_W'(19);
  localparam logic [PHASE_W-1:0] READ_END       = PHASE_W'(18);
  localparam logic [PHASE_W-1:0] READ_FILL      = PHASE_W'(20);
  localparam logic [PHASE_W-1:0] LAST_BIT_PHASE = PHASE_W'(17);
  localparam logic [PHASE_W-1:0] DC_PHASES      = PHASE_W'(2);
  localparam logic [3:0]         FRAME_MSB      = 4'd8;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  typedef struct packed {
    logic cs_n;
    logic clk;
    logic line;
    logic drive;
  } pins_t;

  localparam pins_t PINS_IDLE = '{cs_n: 1'b1, clk: 1'b0, line: 1'b0, drive: 1'b1};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic        is_data;
    logic [15:0] read_count;
    logic        line_in;
  } item_t;

  typedef struct packed {
    pins_t      pins;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       busy;
    logic       rejected;
  } result_t;

endpackage

// ===== src/tws9_if.sv =====
// ----------------------------------------------------------------------------
// tws9 channel interfaces
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface tws9_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic        is_data;
  logic [15:0] read_count;
  logic        line_in;

  modport source (output valid, kind, byte_value, is_data, read_count, line_in,
                  input ready);
  modport sink (input valid, kind, byte_value, is_data, read_count, line_in,
                output ready);
endinterface

interface tws9_res_if;
  logic       valid;
  logic       ready;
  logic       cs_n;
  logic       clk_res;
  logic       line_out;
  logic       line_drive;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, cs_n, clk_res, line_out, line_drive, read_valid,
                  read_data, read_last, busy_res, rejected, input ready);
  modport sink (input valid, cs_n, clk_res, line_out, line_drive, read_valid,
                read_data, read_last, busy_res, rejected, output ready);
endinterface

interface tws9_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/tws9_core.sv =====
// ----------------------------------------------------------------------------
// tws9_core
// Transaction state and next-state logic; advances by one item per step.
// ----------------------------------------------------------------------------
module tws9_core #(
  parameter int unsigned COUNT_BITS = tws9_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              port_enabled,
  input  tws9_pkg::item_t   item,
  output tws9_pkg::result_t result
);
  import tws9_pkg::*;

  logic [1:0]            mode, mode_next;
  logic [PHASE_W-1:0]    phase, phase_next;
  logic [8:0]            out_shift, out_shift_next;
  logic [7:0]            in_shift, in_shift_next;
  logic [COUNT_BITS-1:0] bytes_left, bytes_left_next;
  pins_t                 pins, pins_next;

  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] left_dec;
  logic                  left_is_one;
  logic [3:0]            bit_idx;
  logic                  frame_bit;

  assign cnt         = COUNT_BITS'(item.read_count);
  assign left_dec    = bytes_left - COUNT_BITS'(1);
  assign left_is_one = (bytes_left == COUNT_BITS'(1));
  assign bit_idx     = FRAME_MSB - phase[PHASE_W-1:1];
  assign frame_bit   = out_shift[bit_idx];

  always_comb begin
    logic [COUNT_BITS-1:0] left_after;
    mode_next       = mode;
    phase_next      = phase;
    out_shift_next  = out_shift;
    in_shift_next   = in_shift;
    bytes_left_next = bytes_left;
    pins_next       = pins;
    left_after      = bytes_left;
    result          = '0;

    case (item.kind)
      KIND_WRITE, KIND_READ: begin
        if (mode != MODE_IDLE) begin
          result.rejected = 1'b1;
        end else if (item.kind == KIND_WRITE) begin
          if (port_enabled) begin
            out_shift_next = {item.is_data, item.byte_value};
            mode_next      = MODE_WRITE;
            phase_next     = '0;
            pins_next      = '{cs_n: 1'b0, clk: 1'b0, line: 1'b0, drive: 1'b1};
          end
        end else if (!port_enabled) begin
          // Disabled port: no pin activity, one filler byte per later tick.
          if (cnt != '0) begin
            bytes_left_next = cnt;
            mode_next       = MODE_RDATA;
            phase_next      = READ_FILL;
          end
        end else begin
          out_shift_next  = {1'b0, item.byte_value};
          bytes_left_next = cnt;
          in_shift_next   = '0;
          mode_next       = MODE_RCMD;
          phase_next      = '0;
          pins_next       = '{cs_n: 1'b0, clk: 1'b0, line: 1'b0, drive: 1'b1};
        end
      end
      KIND_TICK: begin
        case (mode)
          MODE_WRITE: begin
            if (phase < FRAME_TICKS) begin
              pins_next  = '{cs_n: 1'b0, clk: phase[0], line: frame_bit, drive: 1'b1};
              phase_next = phase + PHASE_W'(1);
            end else if (phase == WRITE_TAIL) begin
              pins_next  = '{cs_n: 1'b0, clk: 1'b0, line: 1'b0, drive: 1'b1};
              phase_next = WRITE_DONE;
            end else begin
              pins_next  = PINS_IDLE;
              mode_next  = MODE_IDLE;
              phase_next = '0;
            end
          end
          MODE_RCMD: begin
            if (phase < FRAME_TICKS) begin
              pins_next  = '{cs_n: 1'b0, clk: phase[0], line: frame_bit, drive: 1'b1};
              phase_next = phase + PHASE_W'(1);
              if (phase == LAST_BIT_PHASE) begin
                mode_next     = MODE_RDATA;
                phase_next    = (bytes_left != '0) ? '0 : READ_END;
                in_shift_next = '0;
              end
            end else begin
              pins_next  = PINS_IDLE;
              mode_next  = MODE_IDLE;
              phase_next = '0;
            end
          end
          MODE_RDATA: begin
            if (phase == READ_FILL) begin
              if (bytes_left != '0) begin
                result.read_valid = 1'b1;
                result.read_data  = FILL_BYTE;
                result.read_last  = left_is_one;
                left_after        = left_dec;
              end
              bytes_left_next = left_after;
              if (left_after == '0) begin
                pins_next  = PINS_IDLE;
                mode_next  = MODE_IDLE;
                phase_next = '0;
              end
            end else if (phase < DC_PHASES) begin
              // D/C = 1 pulse ahead of each read byte.
              pins_next  = '{cs_n: 1'b0, clk: phase[0], line: 1'b1, drive: 1'b1};
              phase_next = phase + PHASE_W'(1);
            end else if (phase < FRAME_TICKS) begin
              pins_next = '{cs_n: 1'b0, clk: phase[0], line: 1'b0, drive: 1'b0};
              if (!phase[0]) begin
                in_shift_next = {in_shift[6:0], item.line_in};
                phase_next    = phase + PHASE_W'(1);
              end else if (phase == LAST_BIT_PHASE) begin
                result.read_valid = 1'b1;
                result.read_data  = in_shift;
                result.read_last  = left_is_one;
                bytes_left_next   = left_dec;
                phase_next        = (left_dec != '0) ? '0 : READ_END;
                in_shift_next     = '0;
              end else begin
                phase_next = phase + PHASE_W'(1);
              end
            end else begin
              pins_next  = PINS_IDLE;
              mode_next  = MODE_IDLE;
              phase_next = '0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    result.pins = pins_next;
    result.busy = (mode_next != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      phase      <= '0;
      out_shift  <= '0;
      in_shift   <= '0;
      bytes_left <= '0;
      pins       <= PINS_IDLE;
    end else if (step) begin
      mode       <= mode_next;
      phase      <= phase_next;
      out_shift  <= out_shift_next;
      in_shift   <= in_shift_next;
      bytes_left <= bytes_left_next;
      pins       <= pins_next;
    end
  end

endmodule

// ===== src/three_wire_spi_9bit_master.sv =====
// ----------------------------------------------------------------------------
// three_wire_spi_9bit_master
// Three-wire SPI master for 9-bit frames (D/C bit plus 8 data bits).
// ----------------------------------------------------------------------------
// Channels: req carries one item per beat: a tick (one half-period of the
// serial clock), a write request or a read request. res carries exactly one
// result beat per item: pin levels, an optional read byte with its last
// mark, the busy flag and a rejected flag. cfg writes port_enabled and is
// always ready.
// Timing: the result of an item is presented in the cycle after its beat is
// accepted. Throughput: one item per cycle while res takes each result; the
// next-state logic of the transaction sequencer is combinational and the
// result register is the only stage.
// Reset: the sequencer goes idle (CS high, clock low, line driven low),
// port_enabled clears and no result is pending.
// Stall: while a result waits on res, req stays ready only if res.ready
// takes that result in the same cycle, so no beat is dropped or repeated.
// ----------------------------------------------------------------------------
module three_wire_spi_9bit_master #(
  parameter int unsigned COUNT_BITS = tws9_pkg::COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tws9_cfg_if.sink   cfg,
  tws9_req_if.sink   req,
  tws9_res_if.source res
);
  import tws9_pkg::*;

  logic    port_enabled;
  logic    accept;
  logic    out_valid;
  item_t   item;
  result_t result;
  result_t result_q;

  assign cfg.ready = 1'b1;
  assign req.ready = !out_valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign item = '{kind: req.kind, byte_value: req.byte_value, is_data: req.is_data,
                  read_count: req.read_count, line_in: req.line_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enabled <= 1'b0;
    end else if (cfg.valid) begin
      port_enabled <= cfg.data;
    end
  end

  tws9_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .port_enabled(port_enabled),
    .item        (item),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign res.valid      = out_valid;
  assign res.cs_n       = result_q.pins.cs_n;
  assign res.clk_res    = result_q.pins.clk;
  assign res.line_out   = result_q.pins.line;
  assign res.line_drive = result_q.pins.drive;
  assign res.read_valid = result_q.read_valid;
  assign res.read_data  = result_q.read_data;
  assign res.read_last  = result_q.read_last;
  assign res.busy_res   = result_q.busy;
  assign res.rejected   = result_q.rejected;

endmodule

// ===== src/tws9_checker.sv =====
// ----------------------------------------------------------------------------
// tws9_checker
// Port-level checks of the 9-bit three-wire SPI master, bound to the top.
// ----------------------------------------------------------------------------
`include "three_wire_spi_9bit_master_defines.svh"

module tws9_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       cs_n,
  input logic       clk_res,
  input logic       line_out,
  input logic       line_drive,
  input logic       read_valid,
  input logic [7:0] read_data,
  input logic       read_last
);

  // A result beat that is not taken stays presented.
  `TWS9_ASSERT_NEXT(a_res_held, clk, rst, res_valid && !res_ready, res_valid, "result beat dropped while stalled")

  // Without a read byte the data and last mark are quiet.
  `TWS9_ASSERT_SAME(a_no_byte_quiet, clk, rst, res_valid && !read_valid, (read_data == 8'h00) && !read_last, "read fields set without a read byte")

  // A released line always reads low on the host side.
  `TWS9_ASSERT_SAME(a_released_low, clk, rst, res_valid && !line_drive, !line_out, "line driven high while released")

  // With CS high the link is idle: clock low and the host drives the line.
  `TWS9_ASSERT_SAME(a_cs_high_idle, clk, rst, res_valid && cs_n, !clk_res && line_drive, "serial activity while CS is high")

endmodule

bind three_wire_spi_9bit_master tws9_checker u_tws9_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .cs_n      (res.cs_n),
  .clk_res   (res.clk_res),
  .line_out  (res.line_out),
  .line_drive(res.line_drive),
  .read_valid(res.read_valid),
  .read_data (res.read_data),
  .read_last (res.read_last)
);

// ===== tb/sv/three_wire_spi_9bit_master_tb.sv =====
// ----------------------------------------------------------------------------
// three_wire_spi_9bit_master_tb
// Self-checking bench for the 9-bit three-wire SPI master. A scoreboard
// class predicts the pin levels, read bytes, busy and rejected flags of
// every tick or request beat and compares them with each result beat.
// Directed frames and reads come first, then randomized transactions with
// the port switched on and off, while both channels idle and stall.
// ----------------------------------------------------------------------------
import tws9_pkg::*;

localparam logic [1:0] KIND_UNUSED = 2'd3;
localparam pins_t PINS_FRAME_START = '{cs_n: 1'b0, clk: 1'b0, line: 1'b0, drive: 1'b1};

class spi_pin_scoreboard;
  bit                 enabled;
  logic [1:0]         mode;
  logic [PHASE_W-1:0] phase;
  logic [8:0]         frame_bits;
  logic [7:0]         rx_bits;
  logic [15:0]        bytes_left;
  logic [3:0]         bits_done;
  pins_t              pins;
  result_t            due_results[$];
  int                 errors;
  int                 checked;
  int                 writes;
  int                 reads;
  int                 drops;
  int                 bytes_rx;

  function new();
    enabled = 1'b0;
    mode = MODE_IDLE;
    phase = '0;
    frame_bits = '0;
    rx_bits = '0;
    bytes_left = '0;
    bits_done = '0;
    pins = PINS_IDLE;
    errors = 0;
    checked = 0;
    writes = 0;
    reads = 0;
    drops = 0;
    bytes_rx = 0;
  endfunction

  function void set_enabled(bit v);
    enabled = v;
  endfunction

  function void go_idle();
    pins = PINS_IDLE;
    mode = MODE_IDLE;
    phase = '0;
    bits_done = '0;
  endfunction

  // Two half-periods per frame bit, D/C bit first, clock high on odd phases.
  function void shift_frame_bit();
    int sel;
    sel = int'(FRAME_MSB) - int'(phase[PHASE_W-1:1]);
    pins = '{cs_n: 1'b0, clk: phase[0], line: frame_bits[sel], drive: 1'b1};
    phase = phase + PHASE_W'(1);
  endfunction

  function void take_item(item_t it);
    result_t r;
    r = '0;
    if (it.kind == KIND_WRITE || it.kind == KIND_READ) begin
      if (mode != MODE_IDLE) begin
        r.rejected = 1'b1;
        drops++;
      end else if (it.kind == KIND_WRITE) begin
        if (enabled) begin
          frame_bits = {it.is_data, it.byte_value};
          mode = MODE_WRITE;
          phase = '0;
          pins = PINS_FRAME_START;
          writes++;
        end
      end else if (!enabled) begin
        if (it.read_count != 16'd0) begin
          bytes_left = it.read_count;
          mode = MODE_RDATA;
          phase = READ_FILL;
          reads++;
        end
      end else begin
        frame_bits = {1'b0, it.byte_value};
        bytes_left = it.read_count;
        rx_bits = '0;
        bits_done = '0;
        mode = MODE_RCMD;
        phase = '0;
        pins = PINS_FRAME_START;
        reads++;
      end
    end else if (it.kind == KIND_TICK) begin
      case (mode)
        MODE_WRITE: begin
          if (phase < FRAME_TICKS) begin
            shift_frame_bit();
          end else if (phase == WRITE_TAIL) begin
            pins = PINS_FRAME_START;
            phase = WRITE_DONE;
          end else begin
            go_idle();
          end
        end
        MODE_RCMD: begin
          if (phase < FRAME_TICKS) begin
            shift_frame_bit();
            if (phase == FRAME_TICKS) begin
              mode = MODE_RDATA;
              phase = (bytes_left != 16'd0) ? PHASE_W'(0) : READ_END;
              rx_bits = '0;
              bits_done = '0;
            end
          end else begin
            go_idle();
          end
        end
        MODE_RDATA: begin
          if (phase == READ_FILL) begin
            // Port off: one fill byte per tick, no pin activity.
            if (bytes_left != 16'd0) begin
              r.read_valid = 1'b1;
              r.read_data = FILL_BYTE;
              r.read_last = (bytes_left == 16'd1);
              bytes_left = bytes_left - 16'd1;
              bytes_rx++;
            end
            if (bytes_left == 16'd0) go_idle();
          end else if (phase < DC_PHASES) begin
            pins = '{cs_n: 1'b0, clk: phase[0], line: 1'b1, drive: 1'b1};
            phase = phase + PHASE_W'(1);
          end else if (phase < FRAME_TICKS) begin
            pins = '{cs_n: 1'b0, clk: phase[0], line: 1'b0, drive: 1'b0};
            if (!phase[0]) begin
              rx_bits = {rx_bits[6:0], it.line_in};
              bits_done = bits_done + 4'd1;
              phase = phase + PHASE_W'(1);
            end else if (phase == LAST_BIT_PHASE) begin
              r.read_valid = 1'b1;
              r.read_data = rx_bits;
              r.read_last = (bytes_left == 16'd1);
              bytes_left = bytes_left - 16'd1;
              phase = (bytes_left != 16'd0) ? PHASE_W'(0) : READ_END;
              bits_done = '0;
              rx_bits = '0;
              bytes_rx++;
            end else begin
              phase = phase + PHASE_W'(1);
            end
          end else begin
            go_idle();
          end
        end
        default: begin
        end
      endcase
    end
    r.pins = pins;
    r.busy = (mode != MODE_IDLE);
    due_results.push_back(r);
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("MISMATCH on result %0d: %s", checked, what);
  endtask

  task compare_field(string field, logic [7:0] got_v, logic [7:0] want_v);
    if (got_v !== want_v)
      report($sformatf("%s is %0h, expected %0h", field, got_v, want_v));
  endtask

  task check_beat(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      report("result beat arrived with nothing expected");
      return;
    end
    want = due_results.pop_front();
    checked++;
    compare_field("cs_n", 8'(got.pins.cs_n), 8'(want.pins.cs_n));
    compare_field("clk_res", 8'(got.pins.clk), 8'(want.pins.clk));
    compare_field("line_out", 8'(got.pins.line), 8'(want.pins.line));
    compare_field("line_drive", 8'(got.pins.drive), 8'(want.pins.drive));
    compare_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
    compare_field("read_data", got.read_data, want.read_data);
    compare_field("read_last", 8'(got.read_last), 8'(want.read_last));
    compare_field("busy_res", 8'(got.busy), 8'(want.busy));
    compare_field("rejected", 8'(got.rejected), 8'(want.rejected));
  endtask
endclass

module three_wire_spi_9bit_master_tb;
  localparam int HALF_PERIOD  = 5;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 880;
  localparam int LINE_ZERO    = 0;
  localparam int LINE_ONE     = 1;
  localparam int LINE_RANDOM  = 2;

  logic clk;
  logic rst;

  tws9_cfg_if cfg_ch ();
  tws9_req_if req_ch ();
  tws9_res_if res_ch ();

  three_wire_spi_9bit_master dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  spi_pin_scoreboard frame_sb;
  int burst_left   = 0;
  int quiet_cycles = 0;
  int cycle_no     = 0;
  int random_items = 0;
  int stall_style  = 0;
  bit port_on      = 1'b0;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Beats are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        frame_sb.check_beat('{
          pins: '{cs_n: res_ch.cs_n, clk: res_ch.clk_res, line: res_ch.line_out,
                  drive: res_ch.line_drive},
          read_valid: res_ch.read_valid, read_data: res_ch.read_data,
          read_last: res_ch.read_last, busy: res_ch.busy_res,
          rejected: res_ch.rejected});
      if (req_ch.valid && req_ch.ready)
        frame_sb.take_item('{kind: req_ch.kind, byte_value: req_ch.byte_value,
                             is_data: req_ch.is_data, read_count: req_ch.read_count,
                             line_in: req_ch.line_in});
      if (cfg_ch.valid && cfg_ch.ready) frame_sb.set_enabled(cfg_ch.data);
    end
  end

  // Receiver stalls: ready follows one of four stall styles, redrawn at random.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 300 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      2: res_ch.ready <= ((cycle_no % 7) < 4);
      default: res_ch.ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] byte_v,
                           input logic dc, input logic [15:0] count, input logic lvl);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.byte_value <= byte_v;
    req_ch.is_data    <= dc;
    req_ch.read_count <= count;
    req_ch.line_in    <= lvl;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_ticks(input int n, input int line_sel);
    logic lvl;
    for (int i = 0; i < n; i++) begin
      lvl = (line_sel == LINE_RANDOM) ? 1'($urandom) : (line_sel == LINE_ONE);
      send_item(KIND_TICK, 8'($urandom), 1'($urandom), 16'($urandom), lvl);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (frame_sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_port_enable(input bit v);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    port_on = v;
  endtask

  // Mostly complete frames and reads with random content; a few are cut
  // short or overrun, some carry requests mid-flight, some are plain noise.
  task automatic random_transaction();
    int pick;
    int ticks;
    int n;
    logic [15:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_item(KIND_WRITE, 8'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
      ticks = port_on ? 20 : 2;
    end else if (pick < 88) begin
      n = $urandom_range(0, 99);
      if (n < 20) count = 16'd0;
      else if (n < 80) count = 16'($urandom_range(1, 3));
      else count = 16'($urandom_range(4, port_on ? 8 : 40));
      send_item(KIND_READ, 8'($urandom), 1'($urandom), count, 1'($urandom));
      ticks = port_on ? 19 + 18 * int'(count) : int'(count);
    end else begin
      repeat ($urandom_range(1, 4))
        send_item($urandom_range(0, 1) ? KIND_UNUSED : KIND_TICK, 8'($urandom),
                  1'($urandom), 16'($urandom), 1'($urandom));
      ticks = 0;
    end
    random_items += 1 + ticks;
    n = $urandom_range(0, 99);
    if (n < 8) ticks = $urandom_range(0, ticks);
    else if (n < 18) ticks += $urandom_range(1, 3);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 39) == 0)
        send_item($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, 8'($urandom),
                  1'($urandom), 16'($urandom_range(0, 3)), 1'($urandom));
      send_ticks(1, LINE_RANDOM);
    end
  endtask

  initial begin
    frame_sb = new();
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.kind       <= KIND_TICK;
    req_ch.byte_value <= 8'd0;
    req_ch.is_data    <= 1'b0;
    req_ch.read_count <= 16'd0;
    req_ch.line_in    <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Port off after reset: idle tick, unused kind, ignored write, fill reads.
    send_item(KIND_TICK, 8'h00, 1'b0, 16'h0000, 1'b0);
    send_item(KIND_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
    send_item(KIND_WRITE, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
    send_item(KIND_READ, 8'h00, 1'b0, 16'h0000, 1'b0);
    send_item(KIND_READ, 8'h5A, 1'b0, 16'h0003, 1'b0);
    send_item(KIND_WRITE, 8'h00, 1'b0, 16'h0001, 1'b0);
    send_ticks(3, LINE_RANDOM);

    // Port on: command and data frames at the byte extremes, a drop mid-frame.
    write_port_enable(1'b1);
    send_item(KIND_WRITE, 8'h00, 1'b0, 16'h0000, 1'b0);
    send_ticks(9, LINE_RANDOM);
    send_item(KIND_READ, 8'h81, 1'b0, 16'h0002, 1'b0);
    send_ticks(11, LINE_RANDOM);
    send_item(KIND_WRITE, 8'hFF, 1'b1, 16'h0000, 1'b1);
    send_ticks(20, LINE_RANDOM);
    send_item(KIND_READ, 8'h80, 1'b0, 16'h0000, 1'b0);
    send_ticks(19, LINE_RANDOM);
    send_item(KIND_READ, 8'hFF, 1'b1, 16'h0002, 1'b1);
    send_ticks(18, LINE_RANDOM);
    send_ticks(18, LINE_ONE);
    send_ticks(18, LINE_ZERO);
    send_ticks(1, LINE_RANDOM);

    // The enable is only looked at when a request is taken.
    send_item(KIND_WRITE, 8'h3C, 1'b1, 16'h0000, 1'b0);
    send_ticks(7, LINE_RANDOM);
    write_port_enable(1'b0);
    send_ticks(13, LINE_RANDOM);
    send_item(KIND_READ, 8'h01, 1'b0, 16'h0002, 1'b0);
    send_ticks(1, LINE_RANDOM);
    write_port_enable(1'b1);
    send_ticks(1, LINE_RANDOM);

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) write_port_enable(!port_on);
      random_transaction();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d frame writes, %0d reads returning %0d bytes, %0d busy drops",
             frame_sb.writes, frame_sb.reads, frame_sb.bytes_rx, frame_sb.drops);
    $display("%0d result beats compared, %0d mismatches", frame_sb.checked,
             frame_sb.errors);
    if (frame_sb.errors == 0 && frame_sb.due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
